/* rtl/sidac_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sidac_pkg;

    localparam int VALUE_W  = 32;
    localparam int CHAR_W   = 7;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int BITCNT_W = $clog2(VALUE_W);
    localparam int DIGCNT_W = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    typedef logic [BCD_W-1:0] bcd_t;

endpackage

`default_nettype wire

/* rtl/signed_int_to_decimal_ascii_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// The first character (the minus sign when negative) is registered after the request
// is taken, the bit-serial conversion has run and leading zero digits are skipped.
// A new request is taken only in idle, once the last character of the previous one
// has been registered; the conversion is bit-serial shift-and-add-3, one input bit per cycle.
// Reset (aresetn, synchronous, active low) returns to idle with no result pending.
module signed_int_to_decimal_ascii_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [sidac_pkg::VALUE_W-1:0] s_value,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [sidac_pkg::CHAR_W-1:0]  m_char_code,
    output logic                                      m_last
);
    import sidac_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [VALUE_W-1:0]  bin_reg, bin_next;
    bcd_t                bcd_reg, bcd_next;
    bcd_t                bcd_adj;
    logic [BITCNT_W-1:0] bitcnt_reg, bitcnt_next;
    logic [DIGCNT_W-1:0] digcnt_reg, digcnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg, m_char_next;
    logic                m_last_reg, m_last_next;
    logic                out_free;
    logic [3:0]          top_digit;
    logic [VALUE_W-1:0]  raw;

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last      = m_last_reg;

    assign out_free  = !m_valid_reg || m_ready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign raw       = VALUE_W'(s_value);

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        bitcnt_next  = bitcnt_reg;
        digcnt_next  = digcnt_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next    = raw[VALUE_W-1];
                    bin_next    = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
                    bcd_next    = '0;
                    bitcnt_next = '0;
                    digcnt_next = DIGCNT_W'(DIGITS);
                    state_next  = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next    = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next    = {bin_reg[VALUE_W-2:0], 1'b0};
                bitcnt_next = bitcnt_reg + 1'b1;
                if (bitcnt_reg == BITCNT_W'(VALUE_W - 1)) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && digcnt_reg != DIGCNT_W'(1)) begin
                    bcd_next    = {bcd_reg[BCD_W-5:0], 4'd0};
                    digcnt_next = digcnt_reg - 1'b1;
                end else if (neg_reg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_MINUS;
                    m_last_next  = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_ZERO + CHAR_W'(top_digit);
                    m_last_next  = (digcnt_reg == DIGCNT_W'(1));
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    digcnt_next  = digcnt_reg - 1'b1;
                    if (digcnt_reg == DIGCNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg    <= neg_next;
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        bitcnt_reg <= bitcnt_next;
        digcnt_reg <= digcnt_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import sidac_pkg::*;

    localparam int  DIR_N       = 22;
    localparam int  RAND_N      = 398;
    localparam int  DRAIN_WAIT  = 60;
    localparam int  CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } ascii_char_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [VALUE_W-1:0] s_value = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic        [CHAR_W-1:0]  m_char_code;
    logic                      m_last;

    string       request_text = "";
    ascii_char_t pending_chars[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int unsigned send_idle_pct = 33;
    int unsigned recv_idle_pct = 86;

    // directed requests; a non-empty text is the exact expected output
    logic [VALUE_W-1:0] dir_value [DIR_N] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
        32'sd2147483647, 32'h8000_0000, -32'sd2147483647, 32'sd1000000000,
        32'sd999999999, -32'sd1000000000, 32'sd2000000000, -32'sd2000000000,
        32'h5555_5555, 32'hAAAA_AAAA, 32'sd12345, -32'sd987654321,
        32'h0001_0000, -32'sd100000
    };
    string dir_text [DIR_N] = '{
        "0", "1", "-1", "9", "10", "-10", "", "",
        "2147483647", "-2147483648", "-2147483647", "1000000000",
        "999999999", "-1000000000", "2000000000", "-2000000000",
        "", "", "", "",
        "", ""
    };

    signed_int_to_decimal_ascii_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    always #5 aclk = ~aclk;

    task automatic predict_decimal_text(input logic [VALUE_W-1:0] value);
        logic               negative;
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit [DIGITS];
        int                 n;
        int                 i;
        ascii_char_t        c;
        negative = value[VALUE_W-1];
        mag = negative ? (~value + 1'b1) : value;
        n = 0;
        do begin
            digit[n] = 4'(mag % 10);
            mag = mag / 10;
            n++;
        end while (mag != 0 && n < DIGITS);
        if (negative) begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            pending_chars.push_back(c);
        end
        for (i = n - 1; i >= 0; i--) begin
            c.code = CHAR_ZERO + CHAR_W'(digit[i]);
            c.last = (i == 0);
            pending_chars.push_back(c);
        end
    endtask

    task automatic queue_known_text(input string txt);
        ascii_char_t c;
        int          i;
        for (i = 0; i < txt.len(); i++) begin
            c.code = CHAR_W'(txt[i]);
            c.last = (i == txt.len() - 1);
            pending_chars.push_back(c);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned kind;
        int unsigned n;
        longint      lo;
        longint      hi;
        longint      v;
        int          i;
        kind = $urandom_range(9);
        if (kind < 3) begin
            v = $urandom;
        end else if (kind < 9) begin
            // magnitude with a chosen digit count
            n = $urandom_range(1, DIGITS);
            lo = 1;
            for (i = 1; i < n; i++) lo = lo * 10;
            hi = lo * 10 - 1;
            if (n == 1) lo = 0;
            if (hi > 64'd2147483647) hi = 64'd2147483647;
            v = lo + $urandom_range(int'(hi - lo));
            if ($urandom_range(1) == 1) v = -v;
            if (n == DIGITS && v < 0 && $urandom_range(7) == 0) v = -64'd2147483648;
        end else begin
            // powers of ten and their neighbours
            n = $urandom_range(0, DIGITS - 1);
            v = 1;
            for (i = 0; i < n; i++) v = v * 10;
            v = v + $urandom_range(2) - 1;
            if ($urandom_range(1) == 1) v = -v;
        end
        return v[VALUE_W-1:0];
    endfunction

    task automatic send_request(input logic [VALUE_W-1:0] value, input string txt);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_value      <= value;
        request_text <= txt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (request_text.len() != 0) queue_known_text(request_text);
                else predict_decimal_text(s_value);
            end
            if (m_valid && m_ready) begin
                if (pending_chars.size() == 0) begin
                    $error("unexpected char: char_code %0d last %0d", m_char_code, m_last);
                    fail_count++;
                end else begin
                    if (m_char_code !== pending_chars[0].code) begin
                        $error("char_code mismatch: expected %0d, got %0d",
                               pending_chars[0].code, m_char_code);
                        fail_count++;
                    end
                    if (m_last !== pending_chars[0].last) begin
                        $error("last mismatch: expected %0d, got %0d",
                               pending_chars[0].last, m_last);
                        fail_count++;
                    end
                    void'(pending_chars.pop_front());
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < DIR_N; k++) send_request(dir_value[k], dir_text[k]);

        // hold off until the directed output has drained
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_chars.size() != 0) @(posedge aclk);

        for (k = 0; k < RAND_N; k++) begin
            if (k == RAND_N / 3) begin
                send_idle_pct = 86;
                recv_idle_pct = 33;
            end else if (k == 2 * RAND_N / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_request(pick_value(), "");
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
